@@ rtl/eikpu_pkg.sv @@
// Shared types, widths and codes of the eikonal point update block.
package eikpu_pkg;

   // Value format of distances, extension values and grid weights.
   localparam int VW = 32;
   localparam int FB = 16;
   localparam int NAXES = 3;
   localparam int NPAIRS = 3;
   localparam int CSR_IDX_W = 2;

   // Axis pairs in the pairwise difference sum.
   localparam int PAIR_A [NPAIRS] = '{0, 0, 1};
   localparam int PAIR_B [NPAIRS] = '{1, 2, 2};

   // Internal widths, each sized to the largest value it can hold.
   localparam int SA_W = VW + 2;
   localparam int SBT_W = 2 * VW + 1;
   localparam int SB_W = 2 * VW + 3;
   localparam int SBM_W = 2 * VW + 2;
   localparam int WW_W = 2 * VW;
   localparam int TERM_W = 4 * VW;
   localparam int PAIR_W = 4 * VW + 2;
   localparam int LIM_W = SA_W + 3 * FB;
   localparam int RAD_W = LIM_W + (LIM_W % 2);
   localparam int ROOT_W = RAD_W / 2;
   localparam int ISQ_REM_W = ROOT_W + 2;
   localparam int DNUM_W = SBM_W + 1;
   localparam int QB = VW + 1;
   localparam int DF_W = VW + 1;
   localparam int PROD_W = 2 * VW + 1;
   localparam int DEN_W = VW + 3;
   localparam int DENM_W = VW + 2;
   localparam int ENUM_W = 2 * VW + 2;
   localparam int ENM_W = 2 * VW + 1;

   // Distance sentinel and saturation limits.
   localparam logic [VW-1:0] DIST_SENTINEL = {1'b0, {(VW-1){1'b1}}};
   localparam logic [VW-1:0] DIST_NEG_SENTINEL = {1'b1, {(VW-2){1'b0}}, 1'b1};
   localparam logic [VW-1:0] SAT_NEG = {1'b1, {(VW-1){1'b0}}};
   localparam logic [VW-1:0] CFG_RESET = {{(VW-FB-1){1'b0}}, 1'b1, {FB{1'b0}}};

   // Result status codes.
   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_NEG_DISC  = 2'd1,
      STATUS_EXT_UNDEF = 2'd2
   } status_type;

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GRID_WT_X = 2'd0,
      CSR_GRID_WT_Y = 2'd1,
      CSR_GRID_WT_Z = 2'd2
   } csr_index_type;

   // Input transaction.
   typedef struct packed {
      logic signed [VW-1:0] dist_x_minus;
      logic signed [VW-1:0] dist_x_plus;
      logic signed [VW-1:0] dist_y_minus;
      logic signed [VW-1:0] dist_y_plus;
      logic signed [VW-1:0] dist_z_minus;
      logic signed [VW-1:0] dist_z_plus;
      logic signed [VW-1:0] ext_x_minus;
      logic signed [VW-1:0] ext_x_plus;
      logic signed [VW-1:0] ext_y_minus;
      logic signed [VW-1:0] ext_y_plus;
      logic signed [VW-1:0] ext_z_minus;
      logic signed [VW-1:0] ext_z_plus;
   } req_type;

   // Result transaction.
   typedef struct packed {
      logic signed [VW-1:0] new_distance;
      logic signed [VW-1:0] new_extension;
      status_type           status;
   } rsp_type;

   // Chosen neighbor per axis.
   typedef struct packed {
      logic [NAXES-1:0][VW-1:0] d;
      logic [NAXES-1:0][VW-1:0] e;
      logic [NAXES-1:0]         used;
   } point_type;

   // Data riding along the square root pipeline.
   typedef struct packed {
      point_type        pt;
      logic [SA_W-1:0]  sa;
      logic [SBM_W-1:0] sbmag;
      logic             sbneg;
      logic             sbzero;
      logic             negdisc;
   } sq_side_type;

   // Data riding along the distance divider.
   typedef struct packed {
      point_type pt;
      logic      negdisc;
      logic      sbneg;
      logic      special;
   } dd_side_type;

   // Data riding along the extension divider.
   typedef struct packed {
      logic [VW-1:0] x;
      logic          negdisc;
      logic          nneg;
      logic          den_zero;
   } de_side_type;

endpackage

@@ rtl/eikpu_div_pipe.sv @@
// Pipelined restoring divider with round-to-nearest and quotient overflow flag.
module eikpu_div_pipe #(
   parameter int NW = 67,
   parameter int DW = 34,
   parameter int QB = 33,
   parameter int SW = 8
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   input  logic [NW-1:0] in_num,
   input  logic [DW-1:0] in_den,
   input  logic [SW-1:0] in_side,
   output logic          out_valid,
   output logic [QB:0]   out_quot,
   output logic          out_ovf,
   output logic [SW-1:0] out_side
);

   localparam int CW = (NW > DW + QB) ? NW : DW + QB;

   logic          vld_ff  [QB+1];
   logic          ovf_ff  [QB+1];
   logic [NW-1:0] num_ff  [QB+1];
   logic [DW-1:0] den_ff  [QB+1];
   logic [DW:0]   rem_ff  [QB+1];
   logic [QB-1:0] quot_ff [QB+1];
   logic [SW-1:0] side_ff [QB+1];

   logic          fin_vld_ff;
   logic          fin_ovf_ff;
   logic [QB:0]   fin_quot_ff;
   logic [SW-1:0] fin_side_ff;

   logic [CW-1:0] num_c;
   logic [CW-1:0] den_c;
   logic          rnd;

   // Entry stage: a quotient of more than QB bits saturates anyway.
   assign num_c = CW'(in_num);
   assign den_c = CW'(in_den) << QB;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else begin
         vld_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      ovf_ff[0]  <= (num_c >= den_c);
      num_ff[0]  <= in_num;
      den_ff[0]  <= in_den;
      rem_ff[0]  <= (DW+1)'(in_num >> QB);
      quot_ff[0] <= '0;
      side_ff[0] <= in_side;
   end

   // One quotient bit per stage.
   for (genvar k = 1; k <= QB; k++) begin : g_step
      logic [DW:0] trial;
      logic        fits;

      assign trial = {rem_ff[k-1][DW-1:0], num_ff[k-1][QB-k]};
      assign fits  = (trial >= {1'b0, den_ff[k-1]});

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         ovf_ff[k]  <= ovf_ff[k-1];
         num_ff[k]  <= num_ff[k-1];
         den_ff[k]  <= den_ff[k-1];
         side_ff[k] <= side_ff[k-1];
         rem_ff[k]  <= fits ? (trial - {1'b0, den_ff[k-1]}) : trial;
         quot_ff[k] <= {quot_ff[k-1][QB-2:0], fits};
      end
   end

   // Round half away from zero on the magnitude.
   assign rnd = ({rem_ff[QB], 1'b0} >= (DW+2)'(den_ff[QB]));

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_vld_ff <= 1'b0;
      end else begin
         fin_vld_ff <= vld_ff[QB];
      end
   end

   always_ff @(posedge clock) begin
      fin_ovf_ff  <= ovf_ff[QB];
      fin_quot_ff <= (QB+1)'(quot_ff[QB]) + (QB+1)'(rnd);
      fin_side_ff <= side_ff[QB];
   end

   assign out_valid = fin_vld_ff;
   assign out_quot  = fin_quot_ff;
   assign out_ovf   = fin_ovf_ff;
   assign out_side  = fin_side_ff;

endmodule

@@ rtl/eikonal_point_update_with_extension.sv @@
// Top level of the first-order eikonal point update with one extension field.
//
// The block takes one grid point per clock cycle and returns its results in
// order, one result per accepted transaction.
// The pipeline is fixed length: seven stages build the quadratic, a square
// root takes one stage per root bit (41), the distance and extension
// divisions take 35 stages each (one quotient bit per stage), six more
// stages form the distance numerator, pick the distance and form the
// extension sums, and one output register drives the result ports. Results
// are shown for one cycle on rsp_strobe and cannot be held off; busy is high
// only in reset. The 1/dx^2 registers must be written only while no
// transaction is in flight.
module eikonal_point_update_with_extension (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  eikpu_pkg::req_type                 req_data,
   output logic                               rsp_strobe,
   output eikpu_pkg::rsp_type                 rsp_data,
   input  logic                               csr_we,
   input  logic [eikpu_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [eikpu_pkg::VW-1:0]           csr_wdata
);
   import eikpu_pkg::*;

   // Magnitude of a signed value, one bit wider.
   function automatic logic [VW:0] abs_mag(input logic [VW-1:0] v);
      logic [VW:0] x;
      x = {v[VW-1], v};
      return v[VW-1] ? (-x) : x;
   endfunction

   // Signed saturation of a rounded quotient magnitude.
   function automatic logic [VW-1:0] sat_val(input logic [QB:0] q, input logic ovf,
                                             input logic neg);
      logic [VW-1:0] low;
      low = q[VW-1:0];
      if (neg) begin
         if (ovf || (q > (QB+1)'(SAT_NEG))) return SAT_NEG;
         return -low;
      end
      if (ovf || (q > (QB+1)'(DIST_SENTINEL))) return DIST_SENTINEL;
      return low;
   endfunction

   logic in_valid;

   assign busy     = reset;
   assign in_valid = start & ~busy;

   // Configuration registers.
   logic [VW-1:0] grid_wt_ff [NAXES];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < NAXES; a++) grid_wt_ff[a] <= CFG_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_GRID_WT_X: grid_wt_ff[0] <= csr_wdata;
            CSR_GRID_WT_Y: grid_wt_ff[1] <= csr_wdata;
            CSR_GRID_WT_Z: grid_wt_ff[2] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Stage 1: per axis keep the known neighbor of smaller magnitude.
   logic [VW-1:0] dist_m [NAXES];
   logic [VW-1:0] dist_p [NAXES];
   logic [VW-1:0] ext_m  [NAXES];
   logic [VW-1:0] ext_p  [NAXES];
   logic          mk     [NAXES];
   logic          pk     [NAXES];
   logic          use_p  [NAXES];
   point_type     s1_pt_in;
   logic [VW-1:0] s1_wu_in [NAXES];

   assign dist_m[0] = req_data.dist_x_minus;
   assign dist_p[0] = req_data.dist_x_plus;
   assign dist_m[1] = req_data.dist_y_minus;
   assign dist_p[1] = req_data.dist_y_plus;
   assign dist_m[2] = req_data.dist_z_minus;
   assign dist_p[2] = req_data.dist_z_plus;
   assign ext_m[0]  = req_data.ext_x_minus;
   assign ext_p[0]  = req_data.ext_x_plus;
   assign ext_m[1]  = req_data.ext_y_minus;
   assign ext_p[1]  = req_data.ext_y_plus;
   assign ext_m[2]  = req_data.ext_z_minus;
   assign ext_p[2]  = req_data.ext_z_plus;

   always_comb begin
      for (int a = 0; a < NAXES; a++) begin
         mk[a]    = (dist_m[a] != DIST_SENTINEL);
         pk[a]    = (dist_p[a] != DIST_SENTINEL);
         use_p[a] = pk[a] && (!mk[a] || (abs_mag(dist_p[a]) < abs_mag(dist_m[a])));
         s1_pt_in.used[a] = pk[a] || mk[a];
         s1_pt_in.d[a] = use_p[a] ? dist_p[a] : (mk[a] ? dist_m[a] : '0);
         s1_pt_in.e[a] = use_p[a] ? ext_p[a] : (mk[a] ? ext_m[a] : '0);
         s1_wu_in[a] = s1_pt_in.used[a] ? grid_wt_ff[a] : '0;
      end
   end

   logic          s1_v_ff;
   point_type     s1_pt_ff;
   logic [VW-1:0] s1_wu_ff [NAXES];

   always_ff @(posedge clock) begin
      s1_pt_ff <= s1_pt_in;
      s1_wu_ff <= s1_wu_in;
   end

   // Stage 2: weighted distances, weight products, pair differences, weight sum.
   logic signed [SBT_W-1:0] s2_sbt_in [NAXES];
   logic [WW_W-1:0]         s2_ww_in  [NPAIRS];
   logic signed [VW:0]      s2_dd     [NPAIRS];
   logic [VW:0]             s2_ddn    [NPAIRS];
   logic [VW-1:0]           s2_ddm_in [NPAIRS];
   logic [SA_W-1:0]         s2_sa_in;

   always_comb begin
      s2_sa_in = '0;
      for (int a = 0; a < NAXES; a++) begin
         s2_sbt_in[a] = $signed({1'b0, s1_wu_ff[a]}) * $signed(s1_pt_ff.d[a]);
         s2_sa_in = s2_sa_in + SA_W'(s1_wu_ff[a]);
      end
      for (int p = 0; p < NPAIRS; p++) begin
         s2_ww_in[p] = WW_W'(s1_wu_ff[PAIR_A[p]]) * WW_W'(s1_wu_ff[PAIR_B[p]]);
         s2_dd[p] = $signed({s1_pt_ff.d[PAIR_A[p]][VW-1], s1_pt_ff.d[PAIR_A[p]]})
                  - $signed({s1_pt_ff.d[PAIR_B[p]][VW-1], s1_pt_ff.d[PAIR_B[p]]});
         s2_ddn[p] = -s2_dd[p];
         s2_ddm_in[p] = s2_dd[p][VW] ? s2_ddn[p][VW-1:0] : s2_dd[p][VW-1:0];
      end
   end

   logic                    s2_v_ff;
   point_type               s2_pt_ff;
   logic signed [SBT_W-1:0] s2_sbt_ff [NAXES];
   logic [WW_W-1:0]         s2_ww_ff  [NPAIRS];
   logic [VW-1:0]           s2_ddm_ff [NPAIRS];
   logic [SA_W-1:0]         s2_sa_ff;

   always_ff @(posedge clock) begin
      s2_pt_ff  <= s1_pt_ff;
      s2_sbt_ff <= s2_sbt_in;
      s2_ww_ff  <= s2_ww_in;
      s2_ddm_ff <= s2_ddm_in;
      s2_sa_ff  <= s2_sa_in;
   end

   // Stage 3: squared differences and the signed weighted distance sum.
   logic [WW_W-1:0]        s3_df2_in [NPAIRS];
   logic signed [SB_W-1:0] s3_sb_in;

   always_comb begin
      s3_sb_in = '0;
      for (int a = 0; a < NAXES; a++) s3_sb_in = s3_sb_in + SB_W'(s2_sbt_ff[a]);
      for (int p = 0; p < NPAIRS; p++) begin
         s3_df2_in[p] = WW_W'(s2_ddm_ff[p]) * WW_W'(s2_ddm_ff[p]);
      end
   end

   logic                   s3_v_ff;
   point_type              s3_pt_ff;
   logic [WW_W-1:0]        s3_ww_ff  [NPAIRS];
   logic [WW_W-1:0]        s3_df2_ff [NPAIRS];
   logic signed [SB_W-1:0] s3_sb_ff;
   logic [SA_W-1:0]        s3_sa_ff;

   always_ff @(posedge clock) begin
      s3_pt_ff  <= s2_pt_ff;
      s3_ww_ff  <= s2_ww_ff;
      s3_df2_ff <= s3_df2_in;
      s3_sb_ff  <= s3_sb_in;
      s3_sa_ff  <= s2_sa_ff;
   end

   // Stage 4: partial products of the pair terms, sign and magnitude of the sum.
   logic [WW_W-1:0]  s4_pp_in [NPAIRS][4];
   logic [SB_W-1:0]  s4_sbn;
   logic [SBM_W-1:0] s4_sbmag_in;

   always_comb begin
      for (int p = 0; p < NPAIRS; p++) begin
         s4_pp_in[p][0] = WW_W'(s3_ww_ff[p][VW-1:0]) * WW_W'(s3_df2_ff[p][VW-1:0]);
         s4_pp_in[p][1] = WW_W'(s3_ww_ff[p][VW-1:0]) * WW_W'(s3_df2_ff[p][WW_W-1:VW]);
         s4_pp_in[p][2] = WW_W'(s3_ww_ff[p][WW_W-1:VW]) * WW_W'(s3_df2_ff[p][VW-1:0]);
         s4_pp_in[p][3] = WW_W'(s3_ww_ff[p][WW_W-1:VW]) * WW_W'(s3_df2_ff[p][WW_W-1:VW]);
      end
      s4_sbn = -s3_sb_ff;
      s4_sbmag_in = s3_sb_ff[SB_W-1] ? s4_sbn[SBM_W-1:0] : s3_sb_ff[SBM_W-1:0];
   end

   logic             s4_v_ff;
   point_type        s4_pt_ff;
   logic [WW_W-1:0]  s4_pp_ff [NPAIRS][4];
   logic [SBM_W-1:0] s4_sbmag_ff;
   logic             s4_sbneg_ff;
   logic             s4_sbzero_ff;
   logic [SA_W-1:0]  s4_sa_ff;

   always_ff @(posedge clock) begin
      s4_pt_ff     <= s3_pt_ff;
      s4_pp_ff     <= s4_pp_in;
      s4_sbmag_ff  <= s4_sbmag_in;
      s4_sbneg_ff  <= s3_sb_ff[SB_W-1];
      s4_sbzero_ff <= (s3_sb_ff == '0);
      s4_sa_ff     <= s3_sa_ff;
   end

   // Stage 5: assemble each pair term from its partial products.
   logic [TERM_W-1:0] s5_term_in [NPAIRS];

   always_comb begin
      for (int p = 0; p < NPAIRS; p++) begin
         s5_term_in[p] = TERM_W'(s4_pp_ff[p][0])
                       + (TERM_W'(s4_pp_ff[p][1]) << VW)
                       + (TERM_W'(s4_pp_ff[p][2]) << VW)
                       + (TERM_W'(s4_pp_ff[p][3]) << (2 * VW));
      end
   end

   logic              s5_v_ff;
   point_type         s5_pt_ff;
   logic [TERM_W-1:0] s5_term_ff [NPAIRS];
   logic [SBM_W-1:0]  s5_sbmag_ff;
   logic              s5_sbneg_ff;
   logic              s5_sbzero_ff;
   logic [SA_W-1:0]   s5_sa_ff;

   always_ff @(posedge clock) begin
      s5_pt_ff     <= s4_pt_ff;
      s5_term_ff   <= s5_term_in;
      s5_sbmag_ff  <= s4_sbmag_ff;
      s5_sbneg_ff  <= s4_sbneg_ff;
      s5_sbzero_ff <= s4_sbzero_ff;
      s5_sa_ff     <= s4_sa_ff;
   end

   // Stage 6: sum of the pair terms.
   logic [PAIR_W-1:0] s6_pairs_in;

   always_comb begin
      s6_pairs_in = '0;
      for (int p = 0; p < NPAIRS; p++) s6_pairs_in = s6_pairs_in + PAIR_W'(s5_term_ff[p]);
   end

   logic              s6_v_ff;
   point_type         s6_pt_ff;
   logic [PAIR_W-1:0] s6_pairs_ff;
   logic [SBM_W-1:0]  s6_sbmag_ff;
   logic              s6_sbneg_ff;
   logic              s6_sbzero_ff;
   logic [SA_W-1:0]   s6_sa_ff;

   always_ff @(posedge clock) begin
      s6_pt_ff     <= s5_pt_ff;
      s6_pairs_ff  <= s6_pairs_in;
      s6_sbmag_ff  <= s5_sbmag_ff;
      s6_sbneg_ff  <= s5_sbneg_ff;
      s6_sbzero_ff <= s5_sbzero_ff;
      s6_sa_ff     <= s5_sa_ff;
   end

   // Stage 7: quarter discriminant and its sign; loads the square root pipe.
   logic [PAIR_W-1:0] s7_lim;
   logic [PAIR_W-1:0] s7_diff;
   sq_side_type       s7_side_in;

   assign s7_lim  = PAIR_W'(s6_sa_ff) << (3 * FB);
   assign s7_diff = s7_lim - s6_pairs_ff;

   always_comb begin
      s7_side_in.pt      = s6_pt_ff;
      s7_side_in.sa      = s6_sa_ff;
      s7_side_in.sbmag   = s6_sbmag_ff;
      s7_side_in.sbneg   = s6_sbneg_ff;
      s7_side_in.sbzero  = s6_sbzero_ff;
      s7_side_in.negdisc = (s6_pairs_ff > s7_lim);
   end

   logic                 sq_v_ff    [ROOT_W+1];
   sq_side_type          sq_side_ff [ROOT_W+1];
   logic [RAD_W-1:0]     sq_rad_ff  [ROOT_W+1];
   logic [ISQ_REM_W-1:0] sq_rem_ff  [ROOT_W+1];
   logic [ROOT_W-1:0]    sq_root_ff [ROOT_W+1];

   always_ff @(posedge clock) begin
      sq_side_ff[0] <= s7_side_in;
      sq_rad_ff[0]  <= s7_diff[RAD_W-1:0];
      sq_rem_ff[0]  <= '0;
      sq_root_ff[0] <= '0;
   end

   // Valid bits of the front stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff    <= 1'b0;
         s2_v_ff    <= 1'b0;
         s3_v_ff    <= 1'b0;
         s4_v_ff    <= 1'b0;
         s5_v_ff    <= 1'b0;
         s6_v_ff    <= 1'b0;
         sq_v_ff[0] <= 1'b0;
      end else begin
         s1_v_ff    <= in_valid;
         s2_v_ff    <= s1_v_ff;
         s3_v_ff    <= s2_v_ff;
         s4_v_ff    <= s3_v_ff;
         s5_v_ff    <= s4_v_ff;
         s6_v_ff    <= s5_v_ff;
         sq_v_ff[0] <= s6_v_ff;
      end
   end

   // Square root: one root bit per stage, two radicand bits consumed each.
   for (genvar k = 1; k <= ROOT_W; k++) begin : g_sqrt
      logic [ISQ_REM_W-1:0] trial;
      logic [ISQ_REM_W-1:0] test;
      logic                 fits;

      assign trial = {sq_rem_ff[k-1][ISQ_REM_W-3:0], sq_rad_ff[k-1][RAD_W-1 -: 2]};
      assign test  = {sq_root_ff[k-1], 2'b01};
      assign fits  = (trial >= test);

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_v_ff[k] <= 1'b0;
         end else begin
            sq_v_ff[k] <= sq_v_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         sq_side_ff[k] <= sq_side_ff[k-1];
         sq_rad_ff[k]  <= sq_rad_ff[k-1] << 2;
         sq_rem_ff[k]  <= fits ? (trial - test) : trial;
         sq_root_ff[k] <= {sq_root_ff[k-1][ROOT_W-2:0], fits};
      end
   end

   // Distance numerator |SB| + isqrt(Q).
   logic              n1_v_ff;
   logic [DNUM_W-1:0] n1_num_ff;
   logic [SA_W-1:0]   n1_sa_ff;
   dd_side_type       n1_side_ff;
   dd_side_type       n1_side_in;

   always_comb begin
      n1_side_in.pt      = sq_side_ff[ROOT_W].pt;
      n1_side_in.negdisc = sq_side_ff[ROOT_W].negdisc;
      n1_side_in.sbneg   = sq_side_ff[ROOT_W].sbneg;
      n1_side_in.special = sq_side_ff[ROOT_W].sbzero || (sq_side_ff[ROOT_W].sa == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n1_v_ff <= 1'b0;
      end else begin
         n1_v_ff <= sq_v_ff[ROOT_W];
      end
   end

   always_ff @(posedge clock) begin
      n1_num_ff  <= DNUM_W'(sq_side_ff[ROOT_W].sbmag) + DNUM_W'(sq_root_ff[ROOT_W]);
      n1_sa_ff   <= sq_side_ff[ROOT_W].sa;
      n1_side_ff <= n1_side_in;
   end

   // Distance division by the weight sum.
   logic                        d1_v;
   logic [QB:0]                 d1_quot;
   logic                        d1_ovf;
   logic [$bits(dd_side_type)-1:0] d1_side_vec;
   dd_side_type                 d1_side;

   eikpu_div_pipe #(
      .NW (DNUM_W),
      .DW (SA_W),
      .QB (QB),
      .SW ($bits(dd_side_type))
   ) u_div_dist (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (n1_v_ff),
      .in_num    (n1_num_ff),
      .in_den    (n1_sa_ff),
      .in_side   (n1_side_ff),
      .out_valid (d1_v),
      .out_quot  (d1_quot),
      .out_ovf   (d1_ovf),
      .out_side  (d1_side_vec)
   );

   assign d1_side = dd_side_type'(d1_side_vec);

   // New distance: sentinel on a negative discriminant, zero on a zero sum.
   logic [VW-1:0] x_in;

   always_comb begin
      if (d1_side.negdisc) begin
         x_in = d1_side.sbneg ? DIST_NEG_SENTINEL : DIST_SENTINEL;
      end else if (d1_side.special) begin
         x_in = '0;
      end else begin
         x_in = sat_val(d1_quot, d1_ovf, d1_side.sbneg);
      end
   end

   logic          xs_v_ff;
   logic [VW-1:0] xs_x_ff;
   point_type     xs_pt_ff;
   logic          xs_negdisc_ff;

   always_ff @(posedge clock) begin
      xs_x_ff       <= x_in;
      xs_pt_ff      <= d1_side.pt;
      xs_negdisc_ff <= d1_side.negdisc;
   end

   // Extension stage A: differences x - d over the used axes.
   logic signed [DF_W-1:0] ea_df_in [NAXES];

   always_comb begin
      for (int a = 0; a < NAXES; a++) begin
         ea_df_in[a] = xs_pt_ff.used[a]
                     ? ($signed({xs_x_ff[VW-1], xs_x_ff})
                        - $signed({xs_pt_ff.d[a][VW-1], xs_pt_ff.d[a]}))
                     : '0;
      end
   end

   logic                   ea_v_ff;
   logic signed [DF_W-1:0] ea_df_ff [NAXES];
   logic [NAXES-1:0][VW-1:0] ea_e_ff;
   logic [VW-1:0]          ea_x_ff;
   logic                   ea_negdisc_ff;

   always_ff @(posedge clock) begin
      ea_df_ff      <= ea_df_in;
      ea_e_ff       <= xs_pt_ff.e;
      ea_x_ff       <= xs_x_ff;
      ea_negdisc_ff <= xs_negdisc_ff;
   end

   // Extension stage B: products e * (x - d) and the difference sum.
   logic signed [PROD_W-1:0] eb_prod_in [NAXES];
   logic signed [DEN_W-1:0]  eb_den_in;

   always_comb begin
      eb_den_in = '0;
      for (int a = 0; a < NAXES; a++) begin
         eb_prod_in[a] = $signed(ea_e_ff[a]) * ea_df_ff[a];
         eb_den_in = eb_den_in + DEN_W'(ea_df_ff[a]);
      end
   end

   logic                     eb_v_ff;
   logic signed [PROD_W-1:0] eb_prod_ff [NAXES];
   logic signed [DEN_W-1:0]  eb_den_ff;
   logic [VW-1:0]            eb_x_ff;
   logic                     eb_negdisc_ff;

   always_ff @(posedge clock) begin
      eb_prod_ff    <= eb_prod_in;
      eb_den_ff     <= eb_den_in;
      eb_x_ff       <= ea_x_ff;
      eb_negdisc_ff <= ea_negdisc_ff;
   end

   // Extension stage C: numerator sum.
   logic signed [ENUM_W-1:0] ec_num_in;

   always_comb begin
      ec_num_in = '0;
      for (int a = 0; a < NAXES; a++) ec_num_in = ec_num_in + ENUM_W'(eb_prod_ff[a]);
   end

   logic                     ec_v_ff;
   logic signed [ENUM_W-1:0] ec_num_ff;
   logic signed [DEN_W-1:0]  ec_den_ff;
   logic [VW-1:0]            ec_x_ff;
   logic                     ec_negdisc_ff;

   always_ff @(posedge clock) begin
      ec_num_ff     <= ec_num_in;
      ec_den_ff     <= eb_den_ff;
      ec_x_ff       <= eb_x_ff;
      ec_negdisc_ff <= eb_negdisc_ff;
   end

   // Extension stage D: magnitudes and result sign for the division.
   logic [ENUM_W-1:0] ed_numn;
   logic [DEN_W-1:0]  ed_denn;
   de_side_type       ed_side_in;

   assign ed_numn = -ec_num_ff;
   assign ed_denn = -ec_den_ff;

   always_comb begin
      ed_side_in.x        = ec_x_ff;
      ed_side_in.negdisc  = ec_negdisc_ff;
      ed_side_in.nneg     = ec_num_ff[ENUM_W-1] ^ ec_den_ff[DEN_W-1];
      ed_side_in.den_zero = (ec_den_ff == '0);
   end

   logic              ed_v_ff;
   logic [ENM_W-1:0]  ed_nmag_ff;
   logic [DENM_W-1:0] ed_dmag_ff;
   de_side_type       ed_side_ff;

   always_ff @(posedge clock) begin
      ed_nmag_ff <= ec_num_ff[ENUM_W-1] ? ed_numn[ENM_W-1:0] : ec_num_ff[ENM_W-1:0];
      ed_dmag_ff <= ec_den_ff[DEN_W-1] ? ed_denn[DENM_W-1:0] : ec_den_ff[DENM_W-1:0];
      ed_side_ff <= ed_side_in;
   end

   // Valid bits of the middle stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         xs_v_ff <= 1'b0;
         ea_v_ff <= 1'b0;
         eb_v_ff <= 1'b0;
         ec_v_ff <= 1'b0;
         ed_v_ff <= 1'b0;
      end else begin
         xs_v_ff <= d1_v;
         ea_v_ff <= xs_v_ff;
         eb_v_ff <= ea_v_ff;
         ec_v_ff <= eb_v_ff;
         ed_v_ff <= ec_v_ff;
      end
   end

   // Extension division by the difference sum.
   logic                           d2_v;
   logic [QB:0]                    d2_quot;
   logic                           d2_ovf;
   logic [$bits(de_side_type)-1:0] d2_side_vec;
   de_side_type                    d2_side;

   eikpu_div_pipe #(
      .NW (ENM_W),
      .DW (DENM_W),
      .QB (QB),
      .SW ($bits(de_side_type))
   ) u_div_ext (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (ed_v_ff),
      .in_num    (ed_nmag_ff),
      .in_den    (ed_dmag_ff),
      .in_side   (ed_side_ff),
      .out_valid (d2_v),
      .out_quot  (d2_quot),
      .out_ovf   (d2_ovf),
      .out_side  (d2_side_vec)
   );

   assign d2_side = de_side_type'(d2_side_vec);

   // Output register.
   rsp_type rsp_in;
   rsp_type rsp_ff;
   logic    rsp_strobe_ff;

   always_comb begin
      rsp_in.new_distance  = d2_side.x;
      rsp_in.new_extension = d2_side.den_zero ? '0 : sat_val(d2_quot, d2_ovf, d2_side.nneg);
      if (d2_side.negdisc) begin
         rsp_in.status = STATUS_NEG_DISC;
      end else if (d2_side.den_zero) begin
         rsp_in.status = STATUS_EXT_UNDEF;
      end else begin
         rsp_in.status = STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= d2_v;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

`ifndef ASSERT_OFF
   // A negative discriminant always reports a signed sentinel distance.
   a_negdisc_sentinel: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_data.status == STATUS_NEG_DISC)) |->
      ((rsp_data.new_distance == DIST_SENTINEL) ||
       (rsp_data.new_distance == DIST_NEG_SENTINEL)))
      else $error("negative discriminant without sentinel distance");

   // An undefined extension is reported as zero.
   a_ext_undef_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_data.status == STATUS_EXT_UNDEF)) |->
      (rsp_data.new_extension == '0))
      else $error("undefined extension is not zero");

   // Reset flushes every transaction in flight.
   a_reset_flush: assert property (@(posedge clock)
      reset |=> !rsp_strobe)
      else $error("result strobe right after reset");

   // The distance stage only turns valid after a result from the distance divider.
   a_div_valid: assert property (@(posedge clock) disable iff (reset)
      $rose(xs_v_ff) |-> $past(d1_v))
      else $error("distance stage valid without divider result");
`endif

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the eikonal point update block with extension.
`timescale 1ns / 1ps

module tb;
   import eikpu_pkg::*;

   typedef logic signed [255:0] big_t;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_INDEX = 2'd3;
   localparam int STALL_LIMIT = 5000;
   localparam int DRAIN_CYCLES = 200;
   localparam int NPHASES = 6;
   localparam int ITEMS_PER_PHASE = 170;

   // Mirror of the 1/dx^2 registers and the queue of predicted point updates.
   class update_tracker;
      logic [VW-1:0] grid_wt [NAXES];
      rsp_type       pending_updates [$];
      int            mismatches;

      function new();
         foreach (grid_wt[i]) grid_wt[i] = CFG_RESET;
         mismatches = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [VW-1:0] val);
         if (idx == CSR_GRID_WT_X) grid_wt[0] = val;
         else if (idx == CSR_GRID_WT_Y) grid_wt[1] = val;
         else if (idx == CSR_GRID_WT_Z) grid_wt[2] = val;
      endfunction

      // Division rounded to nearest with ties away from zero; both operands positive.
      function big_t div_round(big_t n, big_t d);
         big_t q;
         q = n / d;
         if (2 * (n - q * d) >= d) q = q + 1;
         return q;
      endfunction

      // Clamp a magnitude with sign into the signed value range.
      function logic [VW-1:0] saturate(big_t mag, bit neg);
         big_t lim_pos, lim_neg;
         lim_pos = (big_t'(1) <<< (VW - 1)) - 1;
         lim_neg = big_t'(1) <<< (VW - 1);
         if (neg) return (mag > lim_neg) ? SAT_NEG : VW'(-mag);
         return (mag > lim_pos) ? DIST_SENTINEL : VW'(mag);
      endfunction

      function big_t int_sqrt(big_t a);
         big_t r, c;
         r = 0;
         for (int b = 44; b >= 0; b--) begin
            c = r | (big_t'(1) <<< b);
            if (c * c <= a) r = c;
         end
         return r;
      endfunction

      // Solve the first-order quadratic and form the extension mean.
      function rsp_type solve_point(req_type q);
         logic signed [VW-1:0] dv [6];
         logic signed [VW-1:0] ev [6];
         big_t d [NAXES];
         big_t e [NAXES];
         big_t w [NAXES];
         bit   used [NAXES];
         big_t sa, sb, pairs, lim, dm, dp, x, den, num, df, mag;
         bit   mk, pk;
         status_type st;
         rsp_type res;
         dv = '{q.dist_x_minus, q.dist_x_plus, q.dist_y_minus, q.dist_y_plus,
                q.dist_z_minus, q.dist_z_plus};
         ev = '{q.ext_x_minus, q.ext_x_plus, q.ext_y_minus, q.ext_y_plus,
                q.ext_z_minus, q.ext_z_plus};
         sa = 0;
         sb = 0;
         pairs = 0;
         st = STATUS_OK;
         // Per axis, keep the known neighbor of smaller magnitude; minus wins a tie.
         for (int a = 0; a < NAXES; a++) begin
            dm = dv[2*a];
            dp = dv[2*a+1];
            w[a] = big_t'({1'b0, grid_wt[a]});
            mk = dv[2*a] != DIST_SENTINEL;
            pk = dv[2*a+1] != DIST_SENTINEL;
            used[a] = 1'b1;
            if (pk && (!mk || ((dp < 0 ? -dp : dp) < (dm < 0 ? -dm : dm)))) begin
               d[a] = dp;
               e[a] = ev[2*a+1];
            end else if (mk) begin
               d[a] = dm;
               e[a] = ev[2*a];
            end else begin
               used[a] = 1'b0;
               d[a] = 0;
               e[a] = 0;
            end
            if (used[a]) begin
               sa = sa + w[a];
               sb = sb + w[a] * d[a];
            end
         end
         for (int p = 0; p < NPAIRS; p++)
            if (used[PAIR_A[p]] && used[PAIR_B[p]]) begin
               df = d[PAIR_A[p]] - d[PAIR_B[p]];
               pairs = pairs + w[PAIR_A[p]] * w[PAIR_B[p]] * df * df;
            end
         lim = sa <<< (3 * FB);

         if (pairs > lim) begin
            st = STATUS_NEG_DISC;
            x = (sb < 0) ? -((big_t'(1) <<< (VW - 1)) - 1) : ((big_t'(1) <<< (VW - 1)) - 1);
         end else if (sb == 0 || sa == 0) begin
            x = 0;
         end else begin
            mag = (sb < 0 ? -sb : sb) + int_sqrt(lim - pairs);
            x = big_t'(signed'(saturate(div_round(mag, sa), sb < 0)));
         end
         res.new_distance = VW'(x);

         // Extension uses differences to the saturated new distance.
         den = 0;
         num = 0;
         for (int a = 0; a < NAXES; a++)
            if (used[a]) begin
               den = den + (x - d[a]);
               num = num + e[a] * (x - d[a]);
            end
         if (den == 0) begin
            res.new_extension = '0;
            if (st == STATUS_OK) st = STATUS_EXT_UNDEF;
         end else begin
            res.new_extension = saturate(div_round(num < 0 ? -num : num,
                                                   den < 0 ? -den : den),
                                         (num < 0) ^ (den < 0));
         end
         res.status = st;
         return res;
      endfunction

      function void note_point(req_type q);
         pending_updates.push_back(solve_point(q));
      endfunction

      function void check_update(rsp_type got);
         rsp_type want;
         if (pending_updates.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %h", $time, got);
            mismatches++;
            return;
         end
         want = pending_updates.pop_front();
         if (got.new_distance !== want.new_distance) begin
            $display("%0t: new_distance expected %h actual %h", $time,
                     want.new_distance, got.new_distance);
            mismatches++;
         end
         if (got.new_extension !== want.new_extension) begin
            $display("%0t: new_extension expected %h actual %h", $time,
                     want.new_extension, got.new_extension);
            mismatches++;
         end
         if (got.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
            mismatches++;
         end
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   req_type              req_data = '0;
   logic                 rsp_strobe;
   rsp_type              rsp_data;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [VW-1:0]        csr_wdata = '0;

   update_tracker tracker = new();
   int            idle_pct = 0;
   int            quiet_cycles = 0;

   eikonal_point_update_with_extension dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_strobe(rsp_strobe), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #2 clock = ~clock;

   // Monitor: record accepted transactions, register writes and results.
   always @(posedge clock) begin
      if (!reset && csr_we) tracker.write_reg(csr_index, csr_wdata);
      if (!reset && start && !busy) tracker.note_point(req_data);
      if (!reset && rsp_strobe) tracker.check_update(rsp_data);
      if (reset || (start && !busy) || rsp_strobe) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Offer one transaction and hold it until accepted, then maybe go idle.
   task automatic send_point(req_type q);
      start <= 1'b1;
      req_data <= q;
      do @(posedge clock); while (busy);
      if ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   // One register write, then the write port goes quiet again.
   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [VW-1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Hold the sender until every predicted update has come back.
   task automatic drain_updates();
      start <= 1'b0;
      @(posedge clock);
      while (tracker.pending_updates.size() != 0) @(posedge clock);
   endtask

   function automatic logic [VW-1:0] pick_distance(logic signed [VW-1:0] base);
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 12) return DIST_SENTINEL;
      if (sel < 22) return $urandom;
      if (sel < 26) return SAT_NEG;
      if (sel < 29) return DIST_SENTINEL - 1;
      if (sel < 32) return '0;
      return base + $signed(VW'($urandom_range(0, 6 * 65536))) - 3 * 65536;
   endfunction

   function automatic req_type random_point();
      logic [VW-1:0]        dv [6];
      logic [VW-1:0]        ev [6];
      logic signed [VW-1:0] base;
      base = ($urandom_range(0, 9) == 0) ? VW'($urandom)
             : $signed(VW'($urandom_range(0, 1 << 22))) - (1 << 21);
      foreach (dv[i]) begin
         dv[i] = pick_distance(base);
         ev[i] = ($urandom_range(0, 3) == 0) ? VW'($urandom_range(0, 1 << 18)) : VW'($urandom);
      end
      return {dv[0], dv[1], dv[2], dv[3], dv[4], dv[5],
              ev[0], ev[1], ev[2], ev[3], ev[4], ev[5]};
   endfunction

   // Directed points: empty neighborhoods, ties, extremes, bad discriminants.
   function automatic req_type directed_point(int k);
      logic [VW-1:0] dv [6];
      logic [VW-1:0] ev [6];
      foreach (dv[i]) begin
         dv[i] = DIST_SENTINEL;
         ev[i] = $urandom;
      end
      case (k)
         0: ;
         1: dv[0] = '0;
         2: dv[3] = 32'sd65536;
         3: begin dv[0] = -32'sd5 <<< 16; dv[1] = 32'sd5 <<< 16; end
         4: begin dv[2] = 32'sd3 <<< 16; dv[3] = -32'sd3 <<< 16; end
         5: foreach (dv[i]) dv[i] = '0;
         6: foreach (dv[i]) dv[i] = SAT_NEG;
         7: foreach (dv[i]) dv[i] = DIST_SENTINEL - 1;
         8: begin dv[0] = SAT_NEG; dv[2] = DIST_SENTINEL - 1; dv[4] = '0; end
         9: begin dv[0] = '0; dv[2] = 32'sd100 <<< 16; end
         10: begin dv[1] = 32'sd65536; dv[3] = 32'sd65536; dv[5] = 32'sd65536; end
         11: begin dv[0] = -32'sd65536; dv[2] = -32'sd65536; dv[4] = -32'sd70000; end
         12: begin
            foreach (dv[i]) dv[i] = 32'sd131072;
            foreach (ev[i]) ev[i] = DIST_SENTINEL;
         end
         13: begin
            foreach (dv[i]) dv[i] = -32'sd131072;
            foreach (ev[i]) ev[i] = SAT_NEG;
         end
         14: begin dv[1] = 32'sd40000; dv[2] = 32'sd41000; ev[3] = '0; end
         15: begin dv[0] = DIST_SENTINEL; dv[1] = -32'sd1; dv[5] = 32'sd1; end
         default: foreach (dv[i]) dv[i] = $urandom;
      endcase
      return {dv[0], dv[1], dv[2], dv[3], dv[4], dv[5],
              ev[0], ev[1], ev[2], ev[3], ev[4], ev[5]};
   endfunction

   function automatic logic [VW-1:0] phase_weight(int ph, int ax);
      case (ph)
         0: return CFG_RESET;
         1: return '0;
         2: return '1;
         3: return (ax == 0) ? '0 : (ax == 1) ? CFG_RESET : '1;
         4: return $urandom_range(1 << 12, 1 << 20);
         default: return $urandom;
      endcase
   endfunction

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int ph = 0; ph < NPHASES; ph++) begin
         drain_updates();
         if (ph > 0) begin
            write_csr(CSR_GRID_WT_X, phase_weight(ph, 0));
            write_csr(CSR_GRID_WT_Y, phase_weight(ph, 1));
            write_csr(CSR_GRID_WT_Z, phase_weight(ph, 2));
            if (ph == 2) write_csr(CSR_UNUSED_INDEX, $urandom);
         end
         case (ph % 3)
            0: idle_pct = 0;
            1: idle_pct = 64;
            default: idle_pct = 17;
         endcase
         if (ph == 0 || ph == 2)
            for (int k = 0; k < 20; k++) send_point(directed_point(k));
         for (int n = 0; n < ITEMS_PER_PHASE; n++) send_point(random_point());
      end

      drain_updates();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tracker.mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

@@ eikonal_point_update_with_extension.f @@
rtl/eikpu_pkg.sv
rtl/eikpu_div_pipe.sv
rtl/eikonal_point_update_with_extension.sv
tb/tb.sv
